// ===== hdl/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared constants, types and helpers for the two-heap running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;

	localparam int HEAP_DEPTH = 4096;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
	localparam int COUNT_W    = 14;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [SIZE_W-1:0]            size_t;

	// Input item: one sample, optionally restarting the running set
	typedef struct packed {
		data_t sample;
		logic  restart;
	} sample_item_t;

	// Result item
	typedef struct packed {
		data_t              median;
		logic [COUNT_W-1:0] held_count;
		logic               dropped;
	} median_item_t;

	// Heap operation request from the sequencer to a heap engine.
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_PUSH = 2'd1;
	localparam logic [1:0] OP_POP  = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic       clear;
		data_t      value;
	} heap_req_t;

	typedef struct packed {
		logic  busy;
		size_t size;
		data_t top;
		data_t popped;
	} heap_stat_t;

	// Mean of two values, truncated toward zero, computed one bit wider.
	function automatic data_t mean_tz(data_t a, data_t b);
		logic signed [DATA_WIDTH:0] s;
		logic signed [DATA_WIDTH:0] h;
		begin
			s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
			h = s >>> 1;
			if (s[0] && s[DATA_WIDTH])
				h = h + {{DATA_WIDTH{1'b0}}, 1'b1};
			mean_tz = h[DATA_WIDTH-1:0];
		end
	endfunction

endpackage

// ===== hdl/rmth_stream_if.sv =====
// ----------------------------------------------------------------------------
// rmth_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface rmth_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/rmth_heap.sv =====
// ----------------------------------------------------------------------------
// rmth_heap
// One binary heap held in a synchronous RAM. Push sifts up, pop sifts down,
// one level at a time. Top of heap is kept in a register.
// ----------------------------------------------------------------------------
module rmth_heap
	import rmth_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       is_max,
	input  heap_req_t  req,
	output heap_stat_t stat
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPRD  = 3'd1;
	localparam logic [2:0] ST_UPCMP = 3'd2;
	localparam logic [2:0] ST_DNL   = 3'd3;
	localparam logic [2:0] ST_DNR   = 3'd4;
	localparam logic [2:0] ST_DNCMP = 3'd5;
	localparam logic [2:0] ST_LAST  = 3'd6;

	data_t mem [HEAP_DEPTH];

	logic [2:0] state_q;
	size_t      size_q;
	data_t      top_q;
	data_t      popped_q;
	data_t      val_q;      // element being sifted
	size_t      idx_q;      // its current hole position
	data_t      lval_q;
	data_t      rd_data;

	logic       we;
	addr_t      waddr;
	data_t      wdata;
	addr_t      raddr;

	// True when x belongs above y
	function automatic logic above(logic mx, data_t x, data_t y);
		above = mx ? (x > y) : (x < y);
	endfunction

	size_t parent, lchild, rchild, last_idx;
	assign parent   = (idx_q - size_t'(1)) >> 1;
	assign lchild   = {idx_q[SIZE_W-2:0], 1'b1};
	assign rchild   = lchild + size_t'(1);
	assign last_idx = size_q - size_t'(1);

	// Sift decisions: up_move while climbing, pick_r / pick_l while sinking
	logic up_move, pick_r, pick_l;
	assign up_move = (idx_q != '0) && above(is_max, val_q, rd_data);
	assign pick_r  = (lchild < size_q) && (rchild < size_q) &&
		above(is_max, rd_data, lval_q) && above(is_max, rd_data, val_q);
	assign pick_l  = !pick_r && (lchild < size_q) && above(is_max, lval_q, val_q);

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_data <= mem[raddr];
	end

	// Address and write control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[ADDR_W-1:0];
		wdata = val_q;
		raddr = parent[ADDR_W-1:0];
		case (state_q)
			ST_IDLE:  raddr = last_idx[ADDR_W-1:0];
			ST_UPRD:  raddr = parent[ADDR_W-1:0];
			ST_UPCMP: begin
				we = 1'b1;
				if (up_move)
					wdata = rd_data;
			end
			ST_DNL:   raddr = lchild[ADDR_W-1:0];
			ST_DNR:   raddr = rchild[ADDR_W-1:0];
			// move the chosen child up, or place the element
			ST_DNCMP: begin
				we = 1'b1;
				if (pick_r)
					wdata = rd_data;
				else if (pick_l)
					wdata = lval_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			size_q   <= '0;
			top_q    <= '0;
			popped_q <= '0;
			val_q    <= '0;
			idx_q    <= '0;
			lval_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.clear)
						size_q <= '0;
					else if (req.op == OP_PUSH && size_q < size_t'(HEAP_DEPTH)) begin
						size_q  <= size_q + size_t'(1);
						idx_q   <= size_q;
						val_q   <= req.value;
						state_q <= ST_UPRD;
						if (size_q == '0 || above(is_max, req.value, top_q))
							top_q <= req.value;
					end else if (req.op == OP_POP && size_q != '0) begin
						popped_q <= top_q;
						size_q   <= size_q - size_t'(1);
						idx_q    <= '0;
						state_q  <= ST_LAST;
					end
				end
				ST_UPRD: state_q <= ST_UPCMP;
				ST_UPCMP: begin
					if (up_move) begin
						idx_q   <= parent;
						state_q <= ST_UPRD;
					end else
						state_q <= ST_IDLE;
				end
				// last element was read in idle; now sift it down from root
				ST_LAST: begin
					val_q   <= rd_data;
					top_q   <= rd_data;
					state_q <= ST_DNL;
				end
				ST_DNL: state_q <= ST_DNR;
				ST_DNR: begin
					lval_q  <= rd_data;
					state_q <= ST_DNCMP;
				end
				// rd_data holds the right child here
				ST_DNCMP: begin
					if (pick_r) begin
						if (idx_q == '0) top_q <= rd_data;
						idx_q   <= rchild;
						state_q <= ST_DNL;
					end else if (pick_l) begin
						if (idx_q == '0) top_q <= lval_q;
						idx_q   <= lchild;
						state_q <= ST_DNL;
					end else
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.busy   = (state_q != ST_IDLE);
	assign stat.size   = size_q;
	assign stat.top    = top_q;
	assign stat.popped = popped_q;

endmodule

// ===== hdl/running_median_two_heaps.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median over a signed sample stream using two RAM-based heaps.
//
//   channel  dir  payload
//   in_ch    in   sample, restart
//   out_ch   out  median, held_count, dropped
//
// The insert sifts up one heap level at a time; a rebalance adds a pop
// from the larger heap, sifting down, and a push of the popped value into
// the other heap. The time per item grows with heap depth and is set by
// the single read port of each heap RAM. Reset empties both heaps. A
// result waits in the output register while the next item is taken; a
// new item is held off until the heaps settle and the previous result
// has left.
// ----------------------------------------------------------------------------
module running_median_two_heaps
	import rmth_pkg::*;
(
	input logic clk,
	input logic arst_n,
	rmth_stream_if.sink   in_ch,
	rmth_stream_if.source out_ch
);

	localparam logic [2:0] SQ_IDLE = 3'd0;
	localparam logic [2:0] SQ_INS  = 3'd1;
	localparam logic [2:0] SQ_POP  = 3'd2;
	localparam logic [2:0] SQ_PUSH = 3'd3;
	localparam logic [2:0] SQ_RES  = 3'd4;

	logic [2:0] seq_q;
	logic       drop_q;
	logic       to_upper_q;
	logic       wait_q;
	data_t      samp_q;
	heap_req_t  up_req, lo_req;
	heap_stat_t up_st, lo_st;

	rmth_heap u_upper (.clk(clk), .arst_n(arst_n), .is_max(1'b0), .req(up_req), .stat(up_st));
	rmth_heap u_lower (.clk(clk), .arst_n(arst_n), .is_max(1'b1), .req(lo_req), .stat(lo_st));

	logic out_free;
	assign out_free    = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = (seq_q == SQ_IDLE);

	// heaps settled and the last request has been taken
	logic step_ok, res_fire;
	assign step_ok  = !up_st.busy && !lo_st.busy && !wait_q;
	assign res_fire = (seq_q == SQ_RES) && step_ok && out_free;

	logic  go_up;
	size_t u_sz, l_sz;
	assign u_sz  = up_st.size;
	assign l_sz  = lo_st.size;
	assign go_up = in_ch.payload.restart || u_sz == '0 || in_ch.payload.sample > up_st.top;

	// Requests to the heap engines
	always_comb begin
		up_req = '{op: OP_NONE, clear: 1'b0, value: samp_q};
		lo_req = '{op: OP_NONE, clear: 1'b0, value: samp_q};
		case (seq_q)
			SQ_IDLE: if (in_ch.valid) begin
				up_req.clear = in_ch.payload.restart;
				lo_req.clear = in_ch.payload.restart;
			end
			SQ_INS: if (!wait_q) begin
				if (to_upper_q) up_req.op = OP_PUSH; else lo_req.op = OP_PUSH;
			end
			SQ_POP: if (step_ok) begin
				if (u_sz > l_sz + size_t'(1)) up_req.op = OP_POP;
				else if (l_sz > u_sz + size_t'(1)) lo_req.op = OP_POP;
			end
			SQ_PUSH: if (step_ok) begin
				if (to_upper_q) begin
					lo_req.op = OP_PUSH; lo_req.value = up_st.popped;
				end else begin
					up_req.op = OP_PUSH; up_req.value = lo_st.popped;
				end
			end
			default: ;
		endcase
	end

	// Result composition
	logic [SIZE_W:0] cnt;
	data_t med;
	assign cnt = {1'b0, u_sz} + {1'b0, l_sz};
	always_comb begin
		med = '0;
		if (cnt != '0) begin
			if (cnt[0]) med = (u_sz > l_sz) ? up_st.top : lo_st.top;
			else        med = mean_tz(up_st.top, lo_st.top);
		end
	end

	// Item sequencer and output register; the sample is captured on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q          <= SQ_IDLE;
			wait_q         <= 1'b0;
			to_upper_q     <= 1'b0;
			drop_q         <= 1'b0;
			samp_q         <= '0;
			out_ch.valid   <= 1'b0;
			out_ch.payload <= '0;
		end else begin
			if (res_fire) begin
				out_ch.valid              <= 1'b1;
				out_ch.payload.median     <= med;
				out_ch.payload.held_count <= COUNT_W'(cnt);
				out_ch.payload.dropped    <= drop_q;
			end else if (out_ch.ready)
				out_ch.valid <= 1'b0;
			case (seq_q)
				SQ_IDLE: begin
					wait_q <= in_ch.valid;
					if (in_ch.valid) begin
						to_upper_q <= go_up;
						samp_q     <= in_ch.payload.sample;
						seq_q      <= SQ_INS;
					end
				end
				SQ_INS: begin
					wait_q <= !wait_q;
					if (!wait_q) begin
						drop_q <= to_upper_q ? (u_sz == size_t'(HEAP_DEPTH))
						                     : (l_sz == size_t'(HEAP_DEPTH));
						seq_q  <= SQ_POP;
					end
				end
				SQ_POP: begin
					wait_q <= step_ok;
					if (step_ok) begin
						if (u_sz > l_sz + size_t'(1)) begin
							to_upper_q <= 1'b1; seq_q <= SQ_PUSH;
						end else if (l_sz > u_sz + size_t'(1)) begin
							to_upper_q <= 1'b0; seq_q <= SQ_PUSH;
						end else
							seq_q <= SQ_RES;
					end
				end
				SQ_PUSH: begin
					wait_q <= step_ok;
					if (step_ok)
						seq_q <= SQ_RES;
				end
				SQ_RES: begin
					wait_q <= 1'b0;
					if (res_fire)
						seq_q <= SQ_IDLE;
				end
				default: begin
					wait_q <= 1'b0;
					seq_q  <= SQ_IDLE;
				end
			endcase
		end
	end

	// Assertions
	a_sizes_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_RES && !up_st.busy && !lo_st.busy) |->
		(u_sz <= l_sz + size_t'(1) && l_sz <= u_sz + size_t'(1)))
		else $error("heap sizes unbalanced at result");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(up_st.busy || lo_st.busy) |-> !in_ch.ready)
		else $error("item accepted while a heap is busy");
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !$past(out_ch.valid) && !out_ch.payload.dropped) |->
		out_ch.payload.held_count != '0)
		else $error("stored sample but count is zero");

endmodule
